// ===== src/reaction_propensity_updater_assert.svh =====
// Assertion macros shared by the checker of the propensity updater.
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
`ifndef REACTION_PROPENSITY_UPDATER_ASSERT_SVH
`define REACTION_PROPENSITY_UPDATER_ASSERT_SVH

// Same-cycle implication.
`define RPU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rpu_pkg.sv =====
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared types and constants of the reaction propensity updater.
// ----------------------------------------------------------------------------
package rpu_pkg;

    typedef enum logic [1:0] {
        CMD_DEFINE = 2'd0,
        CMD_SET    = 2'd1,
        CMD_FIRE   = 2'd2,
        CMD_EMIT   = 2'd3
    } cmd_code_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    localparam logic REG_REACTION_COUNT = 1'b0;
    localparam logic REG_COEFF_FRAC     = 1'b1;

    localparam logic [30:0] COUNT_MAX     = 31'h7FFF_FFFF;
    localparam logic [6:0]  FRAC_RESET    = 7'd32;
    localparam logic [2:0]  SLOT_LAST     = 3'd6;

    typedef struct packed {
        logic [1:0]  nr;
        logic [5:0]  reac0;
        logic [5:0]  reac1;
        logic [2:0]  np;
        logic [29:0] prod;
    } shape_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_TERM,
        MS_LO,
        MS_HI,
        MS_SUM,
        MS_SHIFT
    } mstep_t;

    typedef enum logic [1:0] {
        CS_SLOT,
        CS_R0,
        CS_R1
    } cnt_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     def_wr;
        logic     set_wr;
        logic     shape_rd;
        logic     shape_fire;
        logic     fire_cap;
        logic     slot_inc;
        logic     cnt_rd;
        cnt_sel_t cnt_sel;
        logic     upd_wr;
        logic     m_inc;
        logic     dep_cap;
        logic     n0_cap;
        logic     n1_cap;
        mstep_t   mstep;
        logic     push;
        logic     done;
        logic     set_bad;
    } dp_cmd_t;

    typedef struct packed {
        logic fire_ok;
        logic scan_more;
        logic slot_en;
        logic slot_last;
        logic dep;
        logic out_free;
        logic pend_valid;
    } dp_sts_t;

endpackage

// ===== src/reaction_propensity_updater.sv =====
// ----------------------------------------------------------------------------
// reaction_propensity_updater
// Mass-action propensity updater: species counts, reaction table, fire/emit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transfer:
//   define reaction, set species count, fire reaction, emit all propensities.
//   Output channel (out_valid/out_ready) returns one or more results per
//   command; the final one carries last. Define and set answer with a plain
//   acknowledge (has_update low).
//   A fire walks up to seven count updates (a read and a write each), then
//   scans every reaction in use: a shape read and a dependence check for
//   each, and for one that depends also two count reads, term, two 32x32
//   multiplies, sum, shift and push. Emit scans like a fire with every
//   reaction dependent. The scan and the single shared multiplier set the
//   rate; one command is in work at a time.
//   A stalled receiver holds the output register; the scan stops at the next
//   result that finds the one-deep pending buffer full until the transfer frees space.
//   Reset clears the species counts (per-entry valid bits, no sweep),
//   reaction_count to 0 and coeff_frac_bits to 32. Reaction entries are
//   undefined until defined. Configuration writes land at once (cfg_we).
// ----------------------------------------------------------------------------
module reaction_propensity_updater
    import rpu_pkg::*;
#(
    parameter int MAX_SPECIES   = 64,
    parameter int MAX_REACTIONS = 64,
    parameter int MAX_PRODUCTS  = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [5:0]  reaction,
    input  logic [5:0]  species,
    input  logic [30:0] count_value,
    input  logic [1:0]  n_reactants,
    input  logic [5:0]  reactant_a,
    input  logic [5:0]  reactant_b,
    input  logic [2:0]  n_products,
    input  logic [29:0] products_packed,
    input  logic [31:0] coefficient,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  updated_reaction,
    output logic [63:0] propensity,
    output logic        has_update,
    output logic [1:0]  status,
    output logic        last
);

    // command and status between sequencer and datapath
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    rpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    rpu_datapath #(
        .MAX_SPECIES   (MAX_SPECIES),
        .MAX_REACTIONS (MAX_REACTIONS),
        .MAX_PRODUCTS  (MAX_PRODUCTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .reaction         (reaction),
        .species          (species),
        .count_value      (count_value),
        .n_reactants      (n_reactants),
        .reactant_a       (reactant_a),
        .reactant_b       (reactant_b),
        .n_products       (n_products),
        .products_packed  (products_packed),
        .coefficient      (coefficient),
        .cmd              (dp_cmd),
        .sts              (dp_sts),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .updated_reaction (updated_reaction),
        .propensity       (propensity),
        .has_update       (has_update),
        .status           (status),
        .last             (last)
    );

endmodule

// ===== src/rpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpu_ctrl
// Sequencer: steps the datapath through define, set, fire and scan.
// ----------------------------------------------------------------------------
module rpu_ctrl
    import rpu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] command,
    output logic      in_ready,
    input  dp_sts_t   sts,
    output dp_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DEF, S_SET, S_FCHK, S_FCAP, S_UPD_RD, S_UPD_WR,
        S_SCAN_RD, S_SCAN_CHK, S_RD0, S_RD1, S_N1, S_TERM, S_LO,
        S_HI, S_SUM, S_SHIFT, S_PUSH, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (cmd_code_t'(command))
                        CMD_DEFINE: state_next = S_DEF;
                        CMD_SET:    state_next = S_SET;
                        CMD_FIRE:   state_next = S_FCHK;
                        CMD_EMIT:   state_next = S_SCAN_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_DEF:
            begin
                cmd.def_wr = 1'b1;
                state_next = S_DONE;
            end
            S_SET:
            begin
                cmd.set_wr = 1'b1;
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (sts.fire_ok)
                begin
                    cmd.shape_rd   = 1'b1;
                    cmd.shape_fire = 1'b1;
                    state_next     = S_FCAP;
                end
                else
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_FCAP:
            begin
                cmd.fire_cap = 1'b1;
                state_next   = S_UPD_RD;
            end
            S_UPD_RD:
            begin
                if (sts.slot_en)
                begin
                    cmd.cnt_rd  = 1'b1;
                    cmd.cnt_sel = CS_SLOT;
                    state_next  = S_UPD_WR;
                end
                else if (sts.slot_last)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                if (sts.slot_last)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_UPD_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.scan_more)
                begin
                    cmd.shape_rd = 1'b1;
                    state_next   = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.dep_cap = 1'b1;
                if (sts.dep)
                begin
                    state_next = S_RD0;
                end
                else
                begin
                    cmd.m_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_RD0:
            begin
                cmd.cnt_rd  = 1'b1;
                cmd.cnt_sel = CS_R0;
                state_next  = S_RD1;
            end
            S_RD1:
            begin
                cmd.n0_cap  = 1'b1;
                cmd.cnt_rd  = 1'b1;
                cmd.cnt_sel = CS_R1;
                state_next  = S_N1;
            end
            S_N1:
            begin
                cmd.n1_cap = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.mstep  = MS_TERM;
                state_next = S_LO;
            end
            S_LO:
            begin
                cmd.mstep  = MS_LO;
                state_next = S_HI;
            end
            S_HI:
            begin
                cmd.mstep  = MS_HI;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.mstep  = MS_SUM;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.mstep  = MS_SHIFT;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.m_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rpu_datapath.sv =====
// ----------------------------------------------------------------------------
// rpu_datapath
// Species and reaction stores, shared multiplier, result buffer and output.
// ----------------------------------------------------------------------------
module rpu_datapath
    import rpu_pkg::*;
#(
    parameter int MAX_SPECIES   = 64,
    parameter int MAX_REACTIONS = 64,
    parameter int MAX_PRODUCTS  = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic [1:0]  command,
    input  logic [5:0]  reaction,
    input  logic [5:0]  species,
    input  logic [30:0] count_value,
    input  logic [1:0]  n_reactants,
    input  logic [5:0]  reactant_a,
    input  logic [5:0]  reactant_b,
    input  logic [2:0]  n_products,
    input  logic [29:0] products_packed,
    input  logic [31:0] coefficient,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [5:0]  updated_reaction,
    output logic [63:0] propensity,
    output logic        has_update,
    output logic [1:0]  status,
    output logic        last
);

    localparam int SDEPTH = (MAX_SPECIES < 64) ? MAX_SPECIES : 64;
    localparam int SW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int RW     = (MAX_REACTIONS > 1) ? $clog2(MAX_REACTIONS) : 1;
    localparam int PSLOTS = (MAX_PRODUCTS < 5) ? MAX_PRODUCTS : 5;

    function automatic logic sp_ok(logic [5:0] sp);
        return {26'd0, sp} < 32'(MAX_SPECIES);
    endfunction

    function automatic logic sp_match(shape_t f, logic [5:0] sp);
        logic hit;
        hit = 1'b0;
        if (f.nr != 2'd0 && f.reac0 == sp)
        begin
            hit = 1'b1;
        end
        if (f.nr >= 2'd2 && f.reac1 == sp)
        begin
            hit = 1'b1;
        end
        for (int i = 0; i < 5; i++)
        begin
            if (3'(i) < f.np && f.prod[6*i +: 6] == sp)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // configuration
    logic [6:0] rc_reg;
    logic [5:0] fb_reg;
    logic [6:0] nact;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= '0;
            fb_reg <= FRAC_RESET[5:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REACTION_COUNT: rc_reg <= cfg_data;
                REG_COEFF_FRAC:     fb_reg <= cfg_data[5:0];
                default:            rc_reg <= rc_reg;
            endcase
        end
    end

    assign nact = (rc_reg > 7'(MAX_REACTIONS)) ? 7'(MAX_REACTIONS) : rc_reg;

    // latched command fields
    logic        emit_reg;
    logic [5:0]  r_reg;
    logic [5:0]  s_reg;
    logic [30:0] cv_reg;
    shape_t      win_reg;
    logic [31:0] coef_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            emit_reg      <= (cmd_code_t'(command) == CMD_EMIT);
            r_reg         <= reaction;
            s_reg         <= species;
            cv_reg        <= count_value;
            win_reg.nr    <= (n_reactants == 2'd3) ? 2'd2 : n_reactants;
            win_reg.reac0 <= reactant_a;
            win_reg.reac1 <= reactant_b;
            win_reg.np    <= (n_products > 3'(PSLOTS)) ? 3'(PSLOTS) : n_products;
            win_reg.prod  <= products_packed;
            coef_reg      <= coefficient;
        end
    end

    // control counters and status
    logic [2:0] slot_reg;
    logic [6:0] m_reg;
    logic [1:0] st_reg;
    logic       def_ok;
    logic       upd_sat;

    assign def_ok = {26'd0, r_reg} < 32'(MAX_REACTIONS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            m_reg    <= '0;
            st_reg   <= ST_OK;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                slot_reg <= '0;
                m_reg    <= '0;
                st_reg   <= ST_OK;
            end
            else
            begin
                if (cmd.slot_inc)
                begin
                    slot_reg <= slot_reg + 3'd1;
                end
                if (cmd.m_inc)
                begin
                    m_reg <= m_reg + 7'd1;
                end
                if (cmd.set_bad || (cmd.def_wr && !def_ok))
                begin
                    st_reg <= ST_BAD_INDEX;
                end
                else if (cmd.upd_wr && upd_sat)
                begin
                    st_reg <= ST_SATURATED;
                end
            end
        end
    end

    // reaction store
    shape_t      shape_mem [MAX_REACTIONS];
    logic [31:0] coeff_mem [MAX_REACTIONS];
    shape_t      shape_q;
    logic [31:0] coeff_q;
    logic [RW-1:0] shape_addr;

    assign shape_addr = cmd.shape_fire ? r_reg[RW-1:0] : m_reg[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.def_wr && def_ok)
        begin
            shape_mem[r_reg[RW-1:0]] <= win_reg;
            coeff_mem[r_reg[RW-1:0]] <= coef_reg;
        end
        if (cmd.shape_rd)
        begin
            shape_q <= shape_mem[shape_addr];
            coeff_q <= coeff_mem[shape_addr];
        end
    end

    // fired and dependent reaction holding registers
    shape_t      f_reg;
    shape_t      d_reg;
    logic [31:0] dc_reg;
    logic [5:0]  dm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fire_cap)
        begin
            f_reg <= shape_q;
        end
        if (cmd.dep_cap)
        begin
            d_reg  <= shape_q;
            dc_reg <= coeff_q;
            dm_reg <= m_reg[5:0];
        end
    end

    // slot walk over reactants then products of the fired reaction
    logic [5:0] slot_sp;
    logic       slot_reac;
    logic       slot_in;

    always_comb
    begin
        case (slot_reg)
            3'd0:    slot_sp = f_reg.reac0;
            3'd1:    slot_sp = f_reg.reac1;
            3'd2:    slot_sp = f_reg.prod[5:0];
            3'd3:    slot_sp = f_reg.prod[11:6];
            3'd4:    slot_sp = f_reg.prod[17:12];
            3'd5:    slot_sp = f_reg.prod[23:18];
            default: slot_sp = f_reg.prod[29:24];
        endcase
    end

    assign slot_reac = (slot_reg < 3'd2);
    assign slot_in   = slot_reac ? ({1'b0, slot_reg[0]} < f_reg.nr)
                                 : ((slot_reg - 3'd2) < f_reg.np);

    // species count store; an entry never written reads as zero
    logic [30:0]     cnt_mem [SDEPTH];
    logic [SDEPTH-1:0] cnt_vld;
    logic [30:0]     cnt_q;
    logic            cnt_vld_q;
    logic [30:0]     cnt_val;
    logic [5:0]      rd_sp;
    logic            cnt_we;
    logic [SW-1:0]   cnt_waddr;
    logic [30:0]     cnt_wdata;
    logic [30:0]     upd_val;

    always_comb
    begin
        case (cmd.cnt_sel)
            CS_SLOT: rd_sp = slot_sp;
            CS_R0:   rd_sp = d_reg.reac0;
            CS_R1:   rd_sp = d_reg.reac1;
            default: rd_sp = slot_sp;
        endcase
    end

    assign cnt_val = cnt_vld_q ? cnt_q : '0;
    assign upd_sat = slot_reac ? (cnt_val == '0) : (cnt_val == COUNT_MAX);
    assign upd_val = upd_sat ? cnt_val
                   : (slot_reac ? cnt_val - 31'd1 : cnt_val + 31'd1);

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = slot_sp[SW-1:0];
        cnt_wdata = upd_val;
        if (cmd.set_wr && sp_ok(s_reg))
        begin
            cnt_we    = 1'b1;
            cnt_waddr = s_reg[SW-1:0];
            cnt_wdata = cv_reg;
        end
        else if (cmd.upd_wr)
        begin
            cnt_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.cnt_rd)
        begin
            cnt_q <= cnt_mem[rd_sp[SW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld   <= '0;
            cnt_vld_q <= 1'b0;
        end
        else
        begin
            if (cnt_we)
            begin
                cnt_vld[cnt_waddr] <= 1'b1;
            end
            if (cmd.cnt_rd)
            begin
                cnt_vld_q <= sp_ok(rd_sp) && cnt_vld[rd_sp[SW-1:0]];
            end
        end
    end

    // propensity: term, then term * coefficient in two halves, then shift
    logic [30:0] n0_reg;
    logic [30:0] n1_reg;
    logic [61:0] term_reg;
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [95:0] full_reg;
    logic [95:0] shifted;
    logic [63:0] res_prop_reg;
    logic [5:0]  res_rx_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        same;

    assign same = (d_reg.nr >= 2'd2) && (d_reg.reac0 == d_reg.reac1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mstep)
            MS_TERM:
            begin
                case (d_reg.nr)
                    2'd0:
                    begin
                        mul_a = 32'd1;
                        mul_b = 32'd1;
                    end
                    2'd1:
                    begin
                        mul_a = {1'b0, n0_reg};
                        mul_b = 32'd1;
                    end
                    default:
                    begin
                        mul_a = {1'b0, n0_reg};
                        if (same)
                        begin
                            mul_b = (n0_reg == '0) ? 32'd0 : {1'b0, n0_reg - 31'd1};
                        end
                        else
                        begin
                            mul_b = {1'b0, n1_reg};
                        end
                    end
                endcase
            end
            MS_LO:
            begin
                mul_a = term_reg[31:0];
                mul_b = dc_reg;
            end
            MS_HI:
            begin
                mul_a = {2'b00, term_reg[61:32]};
                mul_b = dc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
    assign shifted = full_reg >> fb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.n0_cap)
        begin
            n0_reg <= cnt_val;
        end
        if (cmd.n1_cap)
        begin
            n1_reg <= cnt_val;
        end
        case (cmd.mstep)
            MS_TERM:  term_reg <= same ? mul_p[62:1] : mul_p[61:0];
            MS_LO:    plo_reg  <= mul_p;
            MS_HI:    phi_reg  <= mul_p;
            MS_SUM:   full_reg <= {32'd0, plo_reg} + {phi_reg, 32'd0};
            MS_SHIFT:
            begin
                res_prop_reg <= (|shifted[95:64]) ? '1 : shifted[63:0];
                res_rx_reg   <= dm_reg;
            end
            default:  term_reg <= term_reg;
        endcase
    end

    // one-deep buffer ahead of the output so the final result can carry last
    logic        pend_valid_reg;
    logic [5:0]  pend_rx_reg;
    logic [63:0] pend_prop_reg;
    logic        out_valid_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.done)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.done || (cmd.push && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            pend_rx_reg   <= res_rx_reg;
            pend_prop_reg <= res_prop_reg;
            if (pend_valid_reg)
            begin
                updated_reaction <= pend_rx_reg;
                propensity       <= pend_prop_reg;
                has_update       <= 1'b1;
                status           <= st_reg;
                last             <= 1'b0;
            end
        end
        if (cmd.done)
        begin
            status <= st_reg;
            last   <= 1'b1;
            if (pend_valid_reg)
            begin
                updated_reaction <= pend_rx_reg;
                propensity       <= pend_prop_reg;
                has_update       <= 1'b1;
            end
            else
            begin
                updated_reaction <= '0;
                propensity       <= '0;
                has_update       <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.fire_ok    = {1'b0, r_reg} < nact;
    assign sts.scan_more  = m_reg < nact;
    assign sts.slot_en    = slot_in && sp_ok(slot_sp);
    assign sts.slot_last  = (slot_reg == SLOT_LAST);
    assign sts.dep        = emit_reg
                          || (shape_q.nr != 2'd0 && sp_match(f_reg, shape_q.reac0))
                          || (shape_q.nr >= 2'd2 && sp_match(f_reg, shape_q.reac1));
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;

endmodule

// ===== src/rpu_checker.sv =====
// ----------------------------------------------------------------------------
// rpu_checker
// Port-level checks of the propensity updater, bound to the top level.
// ----------------------------------------------------------------------------
`include "reaction_propensity_updater_assert.svh"

module rpu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  updated_reaction,
    input logic [63:0] propensity,
    input logic        has_update,
    input logic        last
);

    // hold a stalled result
    `RPU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // one command at a time: busy right after a transfer
    `RPU_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "took a second command while busy")
    // a plain acknowledge always ends its command
    `RPU_ASSERT_IMP(a_ack_last, out_valid && !has_update, last, "acknowledge without last")
    // a plain acknowledge carries zero payload
    `RPU_ASSERT_IMP(a_ack_zero, out_valid && !has_update,
        propensity == 64'd0 && updated_reaction == 6'd0, "acknowledge with payload")

endmodule

bind reaction_propensity_updater rpu_checker u_rpu_checker (.*);
